// ===== rtl/pixel_chroma_variance_mask_defines.svh =====
// Assertion macros shared by the checker of the chroma variance mask.
// No dependencies; included by the files that hold assertions.
`ifndef PIXEL_CHROMA_VARIANCE_MASK_DEFINES_SVH
`define PIXEL_CHROMA_VARIANCE_MASK_DEFINES_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define PCVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcvm check failed");

// Non-overlapping implication, checked on every clock edge outside reset.
`define PCVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcvm check failed");

`endif

// ===== rtl/pcvm_pkg.sv =====
// Package of the chroma variance mask: field widths, limits and the item type.
// No dependencies; used by every module of the block but pcvm_ram.
package pcvm_pkg;

  localparam int IDX_W    = 16;
  localparam int CHROMA_W = 8;
  localparam int THRESH_W = 17;
  localparam int FRAME_W  = 16;
  localparam int PROD_W   = THRESH_W + FRAME_W;
  localparam int SQ_W     = 2 * CHROMA_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int SUM_W    = 29;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [CHROMA_W-1:0] u;
    logic [CHROMA_W-1:0] v;
    logic                in_range;
    logic                compare;
    logic                accum;
    logic [PROD_W-1:0]   limit;
  } pcvm_item_t;

endpackage

// ===== rtl/pcvm_ram.sv =====
// Generic simple dual-port RAM with a registered, enabled read port.
// No dependencies; reads return the contents before a same-cycle write.
module pcvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pcvm_queue.sv =====
// Four-entry register queue carrying classified pixels from front to back.
// Depends on pcvm_pkg for the item type.
module pcvm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  pcvm_pkg::pcvm_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output pcvm_pkg::pcvm_item_t pop_item
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  pcvm_pkg::pcvm_item_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != (PW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/pcvm_front.sv =====
// Front end: takes pixel transfers, tracks frame state and classifies each pixel.
// Depends on pcvm_pkg; holds the threshold register and the frame counter.
module pcvm_front #(
  parameter int NUM_PIXELS = 65536,
  parameter int MAX_FRAMES = 4095
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcvm_pkg::THRESH_W-1:0]       cfg_threshold_sq,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pcvm_pkg::IDX_W-1:0]          in_pixel_index,
  input  logic [pcvm_pkg::CHROMA_W-1:0]       in_chroma_u,
  input  logic [pcvm_pkg::CHROMA_W-1:0]       in_chroma_v,
  input  logic                                in_end_of_frame,
  input  logic                                clearing,
  output logic                                push_valid,
  input  logic                                push_ready,
  output pcvm_pkg::pcvm_item_t                push_item
);

  localparam int FW = $clog2(MAX_FRAMES + 1);

  logic [pcvm_pkg::THRESH_W-1:0] thr_r;
  logic                          have_ref_r, have_ref_nxt;
  logic [FW-1:0]                 frames_r, frames_nxt;
  logic                          f_valid_r, f_valid_nxt;
  pcvm_pkg::pcvm_item_t          f_item_r, f_item_nxt;
  logic                          accept, accum, in_range;
  logic [FW-1:0]                 count_n;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !clearing && (!f_valid_r || push_ready);
  assign accept     = in_valid && in_ready;
  assign push_valid = f_valid_r;
  assign push_item  = f_item_r;

  always_comb begin
    in_range = (32'(in_pixel_index) < 32'(NUM_PIXELS));
    accum    = (frames_r < FW'(MAX_FRAMES));
    count_n  = accum ? frames_r + 1'b1 : FW'(MAX_FRAMES);

    f_item_nxt.index    = in_pixel_index;
    f_item_nxt.u        = in_chroma_u;
    f_item_nxt.v        = in_chroma_v;
    f_item_nxt.in_range = in_range;
    f_item_nxt.compare  = in_range && have_ref_r;
    f_item_nxt.accum    = accum;
    f_item_nxt.limit    = pcvm_pkg::PROD_W'(thr_r) * pcvm_pkg::PROD_W'(count_n);

    f_valid_nxt = accept || (f_valid_r && !push_ready);

    have_ref_nxt = have_ref_r;
    frames_nxt   = frames_r;
    if (accept && in_end_of_frame) begin
      if (!have_ref_r) begin
        have_ref_nxt = 1'b1;
      end else if (accum) begin
        frames_nxt = frames_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= '0;
      have_ref_r <= 1'b0;
      frames_r   <= '0;
      f_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_threshold_sq;
      end
      have_ref_r <= have_ref_nxt;
      frames_r   <= frames_nxt;
      f_valid_r  <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// ===== rtl/pcvm_back.sv =====
// Back end: per-pixel memory read-modify-write, saturating sum and mask test.
// Depends on pcvm_pkg and pcvm_ram; clears the sum memory after reset.
module pcvm_back #(
  parameter int NUM_PIXELS = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  pcvm_pkg::pcvm_item_t         pop_item,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcvm_pkg::IDX_W-1:0]   out_pixel_index_out,
  output logic                         out_mask_bit,
  output logic                         out_mask_valid
);

  localparam int DEPTH = (NUM_PIXELS < 65536) ? NUM_PIXELS : 65536;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = pcvm_pkg::SUM_W;

  logic                      clr_r, clr_nxt;
  logic [AW-1:0]             clr_cnt_r, clr_cnt_nxt;

  logic                      s2_valid_r, s3_valid_r, o_valid_r;
  pcvm_pkg::pcvm_item_t      s2_item_r, s3_item_r;
  logic [pcvm_pkg::DIST_W-1:0] s3_dist_r;
  logic [SW-1:0]             s3_sum_r;
  logic [pcvm_pkg::IDX_W-1:0] o_index_r;
  logic                      o_mask_r, o_mvalid_r;

  logic                      h1_valid_r, h2_valid_r;
  logic [AW-1:0]             h1_addr_r, h2_addr_r;
  logic [SW-1:0]             h1_sum_r, h2_sum_r;

  logic                      pop, s2_adv, s3_adv, s3_write;
  logic [AW-1:0]             pop_addr, s3_addr;
  logic [2*pcvm_pkg::CHROMA_W-1:0] prev_rdata;
  logic [SW-1:0]             sum_rdata, sum_src, sum_new;
  logic [SW:0]               sum_wide;
  logic [pcvm_pkg::CHROMA_W-1:0] prev_u, prev_v, du, dv;
  logic [pcvm_pkg::SQ_W-1:0] du_sq, dv_sq;
  logic [pcvm_pkg::DIST_W-1:0] sq_dist;
  logic                      sum_we, mask;
  logic [AW-1:0]             sum_waddr;
  logic [SW-1:0]             sum_wdata;

  assign clearing  = clr_r;
  assign s3_adv    = s3_valid_r && (!o_valid_r || out_ready);
  assign s2_adv    = s2_valid_r && (!s3_valid_r || s3_adv);
  assign pop_ready = !clr_r && (!s2_valid_r || s2_adv);
  assign pop       = pop_valid && pop_ready;
  assign pop_addr  = pop_item.index[AW-1:0];
  assign s3_addr   = s3_item_r.index[AW-1:0];

  pcvm_ram #(
    .WIDTH(2 * pcvm_pkg::CHROMA_W),
    .DEPTH(DEPTH)
  ) u_prev_ram (
    .clk  (clk),
    .we   (pop && pop_item.in_range),
    .waddr(pop_addr),
    .wdata({pop_item.u, pop_item.v}),
    .re   (pop),
    .raddr(pop_addr),
    .rdata(prev_rdata)
  );

  pcvm_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_sum_ram (
    .clk  (clk),
    .we   (sum_we),
    .waddr(sum_waddr),
    .wdata(sum_wdata),
    .re   (pop),
    .raddr(pop_addr),
    .rdata(sum_rdata)
  );

  always_comb begin
    prev_u  = prev_rdata[2*pcvm_pkg::CHROMA_W-1:pcvm_pkg::CHROMA_W];
    prev_v  = prev_rdata[pcvm_pkg::CHROMA_W-1:0];
    du      = (s2_item_r.u > prev_u) ? s2_item_r.u - prev_u : prev_u - s2_item_r.u;
    dv      = (s2_item_r.v > prev_v) ? s2_item_r.v - prev_v : prev_v - s2_item_r.v;
    du_sq   = pcvm_pkg::SQ_W'(du) * pcvm_pkg::SQ_W'(du);
    dv_sq   = pcvm_pkg::SQ_W'(dv) * pcvm_pkg::SQ_W'(dv);
    sq_dist = pcvm_pkg::DIST_W'(du_sq) + pcvm_pkg::DIST_W'(dv_sq);
  end

  // Sums committed by the two items ahead of this one may be missing from the RAM read.
  always_comb begin
    if (h1_valid_r && (h1_addr_r == s3_addr)) begin
      sum_src = h1_sum_r;
    end else if (h2_valid_r && (h2_addr_r == s3_addr)) begin
      sum_src = h2_sum_r;
    end else begin
      sum_src = s3_sum_r;
    end
    sum_wide = (SW+1)'(sum_src) + (SW+1)'(s3_dist_r);
    if (!s3_item_r.accum) begin
      sum_new = sum_src;
    end else if (sum_wide[SW]) begin
      sum_new = pcvm_pkg::SUM_MAX;
    end else begin
      sum_new = sum_wide[SW-1:0];
    end
    mask     = s3_item_r.compare &&
               (pcvm_pkg::PROD_W'(sum_new) > s3_item_r.limit);
    s3_write = s3_adv && s3_item_r.compare && s3_item_r.accum;
  end

  always_comb begin
    sum_we    = clr_r || s3_write;
    sum_waddr = clr_r ? clr_cnt_r : s3_addr;
    sum_wdata = clr_r ? '0 : sum_new;
    clr_nxt     = clr_r && (clr_cnt_r != AW'(DEPTH - 1));
    clr_cnt_nxt = clr_r ? clr_cnt_r + 1'b1 : clr_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_cnt_r  <= '0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
      h1_valid_r <= 1'b0;
      h2_valid_r <= 1'b0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (pop || s2_adv) begin
        s2_valid_r <= pop;
      end
      if (s2_adv || s3_adv) begin
        s3_valid_r <= s2_adv;
      end
      if (s3_adv || out_ready) begin
        o_valid_r <= s3_adv;
      end
      if (s3_adv) begin
        h1_valid_r <= s3_write;
        h2_valid_r <= h1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_item_r <= pop_item;
    end
    if (s2_adv) begin
      s3_item_r <= s2_item_r;
      s3_dist_r <= sq_dist;
      s3_sum_r  <= sum_rdata;
    end
    if (s3_adv) begin
      h1_addr_r  <= s3_addr;
      h1_sum_r   <= sum_new;
      h2_addr_r  <= h1_addr_r;
      h2_sum_r   <= h1_sum_r;
      o_index_r  <= s3_item_r.index;
      o_mask_r   <= mask;
      o_mvalid_r <= s3_item_r.compare;
    end
  end

  assign out_valid           = o_valid_r;
  assign out_pixel_index_out = o_index_r;
  assign out_mask_bit        = o_mask_r;
  assign out_mask_valid      = o_mvalid_r;

endmodule

// ===== rtl/pixel_chroma_variance_mask.sv =====
// Top level of the per-pixel temporal chroma change mask.
// Depends on pcvm_pkg, pcvm_front, pcvm_queue and pcvm_back.
//
// The block takes one pixel transfer per clock while in_ready is high and returns one
// mask result per pixel in input order; a result passes through the front register,
// the queue and the s2, s3 and output registers. The rate is set by the per-pixel read-modify-write
// on the sum memory, which reads and writes one entry each cycle; a forwarding path
// keeps repeated indices exact. After reset the sum memory is cleared one entry per
// cycle, min(NUM_PIXELS, 65536) entries in all, with in_ready low; configuration
// writes are taken at any time and must only be issued while no pixel is in flight.
module pixel_chroma_variance_mask #(
  parameter int NUM_PIXELS = 65536,
  parameter int MAX_FRAMES = 4095
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcvm_pkg::THRESH_W-1:0] cfg_threshold_sq,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcvm_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [pcvm_pkg::CHROMA_W-1:0] in_chroma_u,
  input  logic [pcvm_pkg::CHROMA_W-1:0] in_chroma_v,
  input  logic                          in_end_of_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcvm_pkg::IDX_W-1:0]    out_pixel_index_out,
  output logic                          out_mask_bit,
  output logic                          out_mask_valid
);

  logic                 clearing;
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  pcvm_pkg::pcvm_item_t push_item, pop_item;

  pcvm_front #(
    .NUM_PIXELS(NUM_PIXELS),
    .MAX_FRAMES(MAX_FRAMES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_threshold_sq(cfg_threshold_sq),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_index  (in_pixel_index),
    .in_chroma_u     (in_chroma_u),
    .in_chroma_v     (in_chroma_v),
    .in_end_of_frame (in_end_of_frame),
    .clearing        (clearing),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  pcvm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  pcvm_back #(
    .NUM_PIXELS(NUM_PIXELS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_item           (pop_item),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_index_out(out_pixel_index_out),
    .out_mask_bit       (out_mask_bit),
    .out_mask_valid     (out_mask_valid)
  );

endmodule

// ===== rtl/pcvm_checker.sv =====
// Port-level checker for the chroma variance mask, bound to the top level.
// Depends on pcvm_pkg and the assertion macros in the defines header.
`include "pixel_chroma_variance_mask_defines.svh"

module pcvm_checker #(
  parameter int NUM_PIXELS = 65536
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pcvm_pkg::IDX_W-1:0] out_pixel_index_out,
  input logic                       out_mask_bit,
  input logic                       out_mask_valid
);

  logic                         out_in_range;
  logic [pcvm_pkg::IDX_W+1:0]   out_payload;

  assign out_in_range = (32'(out_pixel_index_out) < 32'(NUM_PIXELS));
  assign out_payload  = {out_pixel_index_out, out_mask_bit, out_mask_valid};

  // A stalled pixel transfer stays offered.
  `PCVM_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

  // A stalled result transfer keeps its payload.
  `PCVM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

  // A pixel is only marked when its mask is valid.
  `PCVM_ASSERT_IMP(a_mask_needs_valid, clk, rst_n, out_valid && out_mask_bit, out_mask_valid)

  // Pixels outside the frame never carry a valid mask.
  `PCVM_ASSERT_IMP(a_range_invalid, clk, rst_n, out_valid && !out_in_range, !out_mask_valid)

endmodule

bind pixel_chroma_variance_mask pcvm_checker #(
  .NUM_PIXELS(NUM_PIXELS)
) u_pcvm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_pixel_index_out(out_pixel_index_out),
  .out_mask_bit       (out_mask_bit),
  .out_mask_valid     (out_mask_valid)
);
